/* design/xcfd_pkg.sv */
package xcfd_pkg;

	localparam int DEFAULT_MAX_ARGS = 64;

	// argument positions are six bits wide on the ports and in requests
	localparam int ARG_IDX_W = 6;
	localparam int ARG_CNT_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ARG_LEN = 2'd1;

	localparam logic [7:0]           START_BYTE_RST  = 8'd126;
	localparam logic [ARG_CNT_W-1:0] MAX_ARG_LEN_RST = 7'd64;

	typedef struct packed {
		logic                 wr_en;
		logic [ARG_IDX_W-1:0] wr_addr;
		logic [7:0]           wr_data;
		logic                 rd_en;
		logic [ARG_IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

/* design/xcfd_argmem.sv */
module xcfd_argmem #(
	parameter int DEPTH = xcfd_pkg::DEFAULT_MAX_ARGS
) (
	input  logic               clk,
	input  xcfd_pkg::mem_req_t req,
	output logic [7:0]         rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/xcfd_ctrl.sv */
module xcfd_ctrl #(
	parameter int MAX_ARGS = xcfd_pkg::DEFAULT_MAX_ARGS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           frame_command,
	output logic [xcfd_pkg::ARG_CNT_W-1:0]       arg_count,
	output logic                                 arg_valid,
	output logic [xcfd_pkg::ARG_IDX_W-1:0]       arg_index,
	output logic [7:0]                           arg_data,
	output logic                                 frame_good,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [7:0]                           cfg_data,
	output xcfd_pkg::mem_req_t                   mem_req,
	input  logic [7:0]                           mem_rd_data
);

	localparam int CW = xcfd_pkg::ARG_CNT_W;
	localparam int IW = xcfd_pkg::ARG_IDX_W;
	localparam logic [CW-1:0] ARGS_LIM = CW'(MAX_ARGS);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_CMD   = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_ARGS  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;
	localparam logic [2:0] PH_RD    = 3'd5;
	localparam logic [2:0] PH_LD    = 3'd6;

	logic [2:0]    phase_q, phase_n;
	logic [7:0]    start_q;
	logic [CW-1:0] max_len_q;
	logic [7:0]    cmd_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] rcv_q;
	logic [7:0]    xor_q;
	logic [IW-1:0] rep_q;

	logic          out_valid_q;
	logic [7:0]    o_cmd_q;
	logic [CW-1:0] o_cnt_q;
	logic          o_av_q;
	logic [IW-1:0] o_idx_q;
	logic [7:0]    o_data_q;
	logic          o_good_q;
	logic          o_last_q;

	logic          in_acc;
	logic          out_take;
	logic [CW-1:0] limit;
	logic [CW-1:0] rcv_inc;
	logic          chk_ok;
	logic          load_chk;
	logic          load_rep;
	logic          rep_last;

	assign cfg_ready = 1'b1;

	assign limit    = (max_len_q < ARGS_LIM) ? max_len_q : ARGS_LIM;
	assign rcv_inc  = rcv_q + CW'(1);
	assign chk_ok   = (xor_q == rx_byte);
	assign rep_last = ((CW'(rep_q) + CW'(1)) == len_q);

	// hold input during replay, and on the check byte until the output slot is free
	assign in_stall = (phase_q == PH_RD) || (phase_q == PH_LD) ||
	                  ((phase_q == PH_CHECK) && out_valid_q);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	assign load_chk = in_acc && (phase_q == PH_CHECK) && (!chk_ok || (len_q == '0));
	assign load_rep = (phase_q == PH_LD) && (!out_valid_q || !out_stall);

	always_comb begin
		mem_req.wr_en   = in_acc && (phase_q == PH_ARGS);
		mem_req.wr_addr = IW'(rcv_q);
		mem_req.wr_data = rx_byte;
		mem_req.rd_en   = (phase_q == PH_RD);
		mem_req.rd_addr = rep_q;
	end

	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_CMD: begin
				if (in_acc) phase_n = PH_LEN;
			end
			PH_LEN: begin
				if (in_acc) begin
					if (rx_byte > {1'b0, limit}) phase_n = PH_HUNT;
					else if (rx_byte == 8'd0)    phase_n = PH_CHECK;
					else                         phase_n = PH_ARGS;
				end
			end
			PH_ARGS: begin
				if (in_acc && (rcv_inc >= len_q)) phase_n = PH_CHECK;
			end
			PH_CHECK: begin
				if (in_acc) begin
					if (chk_ok && (len_q != '0)) phase_n = PH_RD;
					else                         phase_n = PH_HUNT;
				end
			end
			PH_RD: begin
				phase_n = PH_LD;
			end
			PH_LD: begin
				if (load_rep) phase_n = rep_last ? PH_HUNT : PH_RD;
			end
			default: begin
				if (in_acc) phase_n = (rx_byte == start_q) ? PH_CMD : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			start_q     <= xcfd_pkg::START_BYTE_RST;
			max_len_q   <= xcfd_pkg::MAX_ARG_LEN_RST;
			cmd_q       <= '0;
			len_q       <= '0;
			rcv_q       <= '0;
			xor_q       <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == xcfd_pkg::REG_START_BYTE)  start_q   <= cfg_data;
				if (cfg_index == xcfd_pkg::REG_MAX_ARG_LEN) max_len_q <= cfg_data[CW-1:0];
			end
			if (in_acc) begin
				unique case (phase_q)
					PH_CMD: begin
						cmd_q <= rx_byte;
						xor_q <= xor_q ^ rx_byte;
					end
					PH_LEN: begin
						if (rx_byte <= {1'b0, limit}) begin
							len_q <= rx_byte[CW-1:0];
							rcv_q <= '0;
							xor_q <= xor_q ^ rx_byte;
						end
					end
					PH_ARGS: begin
						rcv_q <= rcv_inc;
						xor_q <= xor_q ^ rx_byte;
					end
					PH_CHECK: begin
						rep_q <= '0;
					end
					default: begin
						if (rx_byte == start_q) xor_q <= rx_byte;
					end
				endcase
			end
			if (load_rep && !rep_last) rep_q <= rep_q + IW'(1);
			if (load_chk || load_rep)  out_valid_q <= 1'b1;
			else if (out_take)         out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_chk) begin
			o_cmd_q  <= cmd_q;
			o_cnt_q  <= len_q;
			o_av_q   <= 1'b0;
			o_idx_q  <= '0;
			o_data_q <= '0;
			o_good_q <= chk_ok;
			o_last_q <= 1'b1;
		end else if (load_rep) begin
			o_cmd_q  <= cmd_q;
			o_cnt_q  <= len_q;
			o_av_q   <= 1'b1;
			o_idx_q  <= rep_q;
			o_data_q <= mem_rd_data;
			o_good_q <= 1'b1;
			o_last_q <= rep_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_command = o_cmd_q;
	assign arg_count     = o_cnt_q;
	assign arg_valid     = o_av_q;
	assign arg_index     = o_idx_q;
	assign arg_data      = o_data_q;
	assign frame_good    = o_good_q;
	assign last          = o_last_q;

`ifndef SYNTH
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("argument buffer read and written in one cycle");

	a_args_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ARGS) |-> (rcv_q < len_q) && (len_q <= ARGS_LIM))
		else $error("argument count outside frame length");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_last_q && o_av_q) |-> ((CW'(o_idx_q) + CW'(1)) == o_cnt_q))
		else $error("last argument result at wrong index");

	a_replay_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rep && rep_last) |=> (phase_q == PH_HUNT) && out_valid_q)
		else $error("replay did not finish after its last argument");
`endif

endmodule

/* design/xor_checked_frame_deframer.sv */
// Deframer for serial frames: start byte, command, length, length argument bytes, XOR
// check byte. Bytes are taken one per clock while a frame is parsed; argument bytes go
// into a single-port-read buffer of MAX_ARGS entries. A good frame with n arguments is
// replayed as n results, each needing one buffer read and one output-register load, so
// input is held after its check byte until the replay is done; a bad or empty frame gives one
// result at once. The check byte is also held while an earlier result still waits in the
// output register. Configuration writes are always taken.
module xor_checked_frame_deframer #(
	parameter int MAX_ARGS = xcfd_pkg::DEFAULT_MAX_ARGS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     frame_command,
	output logic [xcfd_pkg::ARG_CNT_W-1:0] arg_count,
	output logic                           arg_valid,
	output logic [xcfd_pkg::ARG_IDX_W-1:0] arg_index,
	output logic [7:0]                     arg_data,
	output logic                           frame_good,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	xcfd_pkg::mem_req_t mem_req;
	logic [7:0]         mem_rd_data;

	xcfd_ctrl #(
		.MAX_ARGS(MAX_ARGS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_command(frame_command),
		.arg_count    (arg_count),
		.arg_valid    (arg_valid),
		.arg_index    (arg_index),
		.arg_data     (arg_data),
		.frame_good   (frame_good),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mem_req      (mem_req),
		.mem_rd_data  (mem_rd_data)
	);

	xcfd_argmem #(
		.DEPTH(MAX_ARGS)
	) u_argmem (
		.clk    (clk),
		.req    (mem_req),
		.rd_data(mem_rd_data)
	);

endmodule

/* tb/sv/tb_xor_checked_frame_deframer.sv */
module tb_xor_checked_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_DEPTH     = xcfd_pkg::DEFAULT_MAX_ARGS;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 28;
	localparam int SETTLE        = 20;
	localparam int END_SETTLE    = 150;
	localparam int STALL_LIMIT   = 2000;
	localparam int MAX_ERR_SHOWN = 10;

	// indexes past the register list; writes to them must change nothing
	localparam logic [xcfd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [xcfd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [2:0] HUNT      = 3'd0;
	localparam logic [2:0] GET_CMD   = 3'd1;
	localparam logic [2:0] GET_LEN   = 3'd2;
	localparam logic [2:0] GET_ARGS  = 3'd3;
	localparam logic [2:0] GET_CHECK = 3'd4;

	typedef struct packed {
		logic [7:0]                     command;
		logic [xcfd_pkg::ARG_CNT_W-1:0] arg_cnt;
		logic                           arg_vld;
		logic [xcfd_pkg::ARG_IDX_W-1:0] arg_pos;
		logic [7:0]                     arg_byte;
		logic                           good;
		logic                           last_res;
	} frame_res_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		frame_res_t res;
	} stim_row_t;

	// reset settings: start byte 7E, longest argument run 64
	localparam stim_row_t DIRECTED [24] = '{
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		// empty frame, good check
		'{8'h7E, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h7E, 1'b1, '{8'h00, 7'd0, 1'b0, 6'd0, 8'h00, 1'b1, 1'b1}},
		// bad check
		'{8'h7E, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{8'hFF, 7'd0, 1'b0, 6'd0, 8'h00, 1'b0, 1'b1}},
		// start byte inside the arguments is plain data
		'{8'h7E, 1'b0, '0},
		'{8'h5A, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h7E, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hA7, 1'b0, '0},
		// one past the longest run: drop and hunt again
		'{8'h7E, 1'b0, '0},
		'{8'h11, 1'b0, '0},
		'{8'h41, 1'b0, '0},
		'{8'h7E, 1'b0, '0},
		'{8'h33, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'hCC, 1'b1, '{8'h33, 7'd1, 1'b1, 6'd0, 8'h80, 1'b1, 1'b1}}
	};

	localparam logic [7:0] PH_START     [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h7E, 8'h00};
	localparam bit         PH_START_RND [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam logic [7:0] PH_MAXLEN    [PHASES] = '{8'd64, 8'd0, 8'd3, 8'hFF, 8'd5, 8'd1};
	localparam int         PH_SEND_IDLE [PHASES] = '{0, 85, 0, 13, 0, 13};
	localparam int         PH_RECV_STALL[PHASES] = '{0, 0, 85, 13, 0, 13};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     rx_byte;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     frame_command;
	logic [xcfd_pkg::ARG_CNT_W-1:0] arg_count;
	logic                           arg_valid;
	logic [xcfd_pkg::ARG_IDX_W-1:0] arg_index;
	logic [7:0]                     arg_data;
	logic                           frame_good;
	logic                           last;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [xcfd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                     cfg_data;

	// predictor copy of the registers and parse state
	logic [7:0]                     start_reg;
	logic [xcfd_pkg::ARG_CNT_W-1:0] max_len_reg;
	logic [2:0]                     parse_state;
	logic [7:0]                     cmd_hold;
	logic [xcfd_pkg::ARG_CNT_W-1:0] frame_len;
	logic [xcfd_pkg::ARG_CNT_W-1:0] args_seen;
	logic [7:0]                     check_acc;
	logic [7:0]                     arg_store [BUF_DEPTH];

	frame_res_t replay_due [$];
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         err_count      = 0;
	int         quiet_cycles   = 0;

	xor_checked_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_command(frame_command),
		.arg_count    (arg_count),
		.arg_valid    (arg_valid),
		.arg_index    (arg_index),
		.arg_data     (arg_data),
		.frame_good   (frame_good),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1ns clk = ~clk;

	function automatic int arg_limit();
		return (int'(max_len_reg) < BUF_DEPTH) ? int'(max_len_reg) : BUF_DEPTH;
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b, ref frame_res_t res_q[$]);
		int i;
		unique case (parse_state)
		GET_CMD: begin
			cmd_hold    = b;
			check_acc   ^= b;
			parse_state = GET_LEN;
		end
		GET_LEN: begin
			if (int'(b) > arg_limit()) begin
				parse_state = HUNT;
			end else begin
				frame_len   = b[xcfd_pkg::ARG_CNT_W-1:0];
				args_seen   = '0;
				check_acc   ^= b;
				parse_state = (b != 8'd0) ? GET_ARGS : GET_CHECK;
			end
		end
		GET_ARGS: begin
			arg_store[args_seen[xcfd_pkg::ARG_IDX_W-1:0]] = b;
			args_seen = args_seen + xcfd_pkg::ARG_CNT_W'(1);
			check_acc ^= b;
			if (args_seen >= frame_len) begin
				parse_state = GET_CHECK;
			end
		end
		GET_CHECK: begin
			if (check_acc != b) begin
				res_q.push_back(frame_res_t'{cmd_hold, frame_len, 1'b0, '0, '0, 1'b0, 1'b1});
			end else if (frame_len == '0) begin
				res_q.push_back(frame_res_t'{cmd_hold, frame_len, 1'b0, '0, '0, 1'b1, 1'b1});
			end else begin
				for (i = 0; i < int'(frame_len); i++) begin
					res_q.push_back(frame_res_t'{cmd_hold, frame_len, 1'b1,
						i[xcfd_pkg::ARG_IDX_W-1:0], arg_store[i], 1'b1,
						1'(i + 1 == int'(frame_len))});
				end
			end
			parse_state = HUNT;
		end
		default: begin
			if (b == start_reg) begin
				check_acc   = b;
				parse_state = GET_CMD;
			end
		end
		endcase
	endfunction

	function automatic string fmt_res(input frame_res_t r);
		return $sformatf("cmd=%h cnt=%0d av=%b idx=%0d data=%h good=%b last=%b",
			r.command, r.arg_cnt, r.arg_vld, r.arg_pos, r.arg_byte, r.good, r.last_res);
	endfunction

	function automatic void log_error(input string msg);
		err_count++;
		if (err_count <= MAX_ERR_SHOWN) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// append one frame, mostly well formed, to the byte stream
	function automatic void add_frame(ref logic [7:0] s[$]);
		int         lim;
		int         len;
		int         r;
		logic [7:0] cmd;
		logic [7:0] chk;
		logic [7:0] arg;
		lim = arg_limit();
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(99);
		if (r < 75) begin
			len = $urandom_range(0, (lim < 4) ? lim : 4);
		end else if (r < 85) begin
			len = $urandom_range(0, (lim < 12) ? lim : 12);
		end else if (r < 90) begin
			len = lim;
		end else begin
			len = $urandom_range(1) ? lim + 1 : $urandom_range(lim + 1, 255);
		end
		cmd = 8'($urandom_range(0, 255));
		chk = start_reg ^ cmd ^ 8'(len);
		s.push_back(start_reg);
		s.push_back(cmd);
		s.push_back(8'(len));
		if (len > lim) return;
		repeat (len) begin
			arg = 8'($urandom_range(0, 255));
			chk ^= arg;
			s.push_back(arg);
		end
		// cut the frame short: the next frame's first byte then lands as its check byte
		if ($urandom_range(99) < 6) return;
		if ($urandom_range(99) < 20) begin
			chk ^= 8'($urandom_range(1, 255));
		end
		s.push_back(chk);
	endfunction

	task automatic send_rx(input logic [7:0] b, input logic typed, input frame_res_t typed_res);
		frame_res_t produced [$];
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom_range(0, 255));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		// hold the request until the deframer takes it
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_rx_byte(b, produced);
		if (typed) begin
			replay_due.push_back(typed_res);
		end else begin
			foreach (produced[k]) replay_due.push_back(produced[k]);
		end
	endtask

	task automatic write_reg(input logic [xcfd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		unique case (idx)
		xcfd_pkg::REG_START_BYTE: begin
			start_reg = val;
		end
		xcfd_pkg::REG_MAX_ARG_LEN: begin
			max_len_reg = val[xcfd_pkg::ARG_CNT_W-1:0];
		end
		default: begin
		end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (replay_due.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		frame_res_t seen;
		frame_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{frame_command, arg_count, arg_valid, arg_index, arg_data, frame_good, last};
			if (replay_due.size() == 0) begin
				log_error({"result with none pending: ", fmt_res(seen)});
			end else begin
				want = replay_due.pop_front();
				if (seen !== want) begin
					log_error({"result mismatch: exp ", fmt_res(want), " got ", fmt_res(seen)});
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] stream [$];
		logic [7:0] carry [$];
		int         hold;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		cfg_valid   = 1'b0;
		cfg_index   = xcfd_pkg::REG_START_BYTE;
		cfg_data    = 8'h00;
		start_reg   = xcfd_pkg::START_BYTE_RST;
		max_len_reg = xcfd_pkg::MAX_ARG_LEN_RST;
		parse_state = HUNT;
		cmd_hold    = '0;
		frame_len   = '0;
		args_seen   = '0;
		check_acc   = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[r]) send_rx(DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].res);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle(SETTLE);
			write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
			write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
			write_reg(xcfd_pkg::REG_START_BYTE,
				PH_START_RND[p] ? 8'($urandom_range(0, 255)) : PH_START[p]);
			write_reg(xcfd_pkg::REG_MAX_ARG_LEN, PH_MAXLEN[p]);
			send_idle_pct  = PH_SEND_IDLE[p];
			recv_stall_pct = PH_RECV_STALL[p];
			stream = carry;
			carry  = {};
			while (stream.size() < PHASE_ITEMS) add_frame(stream);
			// leave the tail of a frame for the next setting, so the start byte
			// changes while that frame is open
			hold = (p == PHASES - 1) ? 0 : $urandom_range(0, 3);
			repeat (hold) carry.push_front(stream.pop_back());
			foreach (stream[i]) send_rx(stream[i], 1'b0, '0);
		end

		wait_idle(END_SETTLE);
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
